// ----- design/fcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared widths, result codes and controller/datapath interface structs for
// the frequency-aged cache replacement block.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned KIND_W = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_CACHED = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_EVICT  = 2'd2
  } kind_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic lookup;
    logic update;
    logic scan_start;
    logic scan_mm;
    logic calc;
    logic scan_ev;
    logic final_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_new;
    logic full;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ----- design/frequency_aged_cache_replacement_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_aged_cache_replacement_top
// LFU slot list with aging: per-item saturating use counters, full-list
// aging around the min/max average, eviction in slot order and compaction.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | item_id_i
//   out     | output    | out_valid_o/ out_stall_i| result_id_o, result_kind_o,
//           |           |                         | use_count_o, last_o
//
// A hit, or an insert into a list that is not full, skips the aging scans.
// An insert into a full list makes two passes over the slot memory through a
// two-stage read pipeline (slot, then counter), plus the average calculation.
// After reset the counter memory is zeroed, one entry a cycle, over all ITEM_IDS
// entries; in_stall_o stays high until that pass ends.
// A stalled result register holds the eviction pass at the offending beat.
// ----------------------------------------------------------------------------
module frequency_aged_cache_replacement_top #(
  parameter int unsigned SLOTS    = 32,
  parameter int unsigned ITEM_IDS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [fcr_pkg::ID_W-1:0]   item_id_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fcr_pkg::ID_W-1:0]   result_id_o,
  output logic [fcr_pkg::KIND_W-1:0] result_kind_o,
  output logic [fcr_pkg::CNT_W-1:0]  use_count_o,
  output logic                       last_o
);

  fcr_pkg::cmd_t cmd;
  fcr_pkg::sts_t sts;

  fcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcr_datapath #(
    .SLOTS    (SLOTS),
    .ITEM_IDS (ITEM_IDS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_id_i     (item_id_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_id_o   (result_id_o),
    .result_kind_o (result_kind_o),
    .use_count_o   (use_count_o),
    .last_o        (last_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a beat is still in progress");

  a_final_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.final_load |-> sts.out_free)
    else $error("final result loaded over a pending beat");

  a_scan_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd.scan_mm) |-> sts.full)
    else $error("aging started on a list that is not full");

  a_aged_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.scan_ev && sts.scan_done) |=> !sts.full)
    else $error("aging left no free slot");

endmodule

// ----- design/fcr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_ctrl
// Sequencer: clearing pass, counter lookup and update, min/max scan, average
// calculation, eviction scan and final result.
// ----------------------------------------------------------------------------
module fcr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fcr_pkg::sts_t sts_i,
  output fcr_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_SCAN_MM,
    ST_CALC,
    ST_SCAN_EV,
    ST_FINAL
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (sts_i.is_new && sts_i.full) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN_MM;
        end else begin
          state_d = ST_FINAL;
        end
      end
      ST_SCAN_MM: begin
        cmd_o.scan_mm = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc       = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        cmd_o.scan_ev = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.final_load = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- design/fcr_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcr_datapath
// Counter and slot memories, two-stage scan pipeline, min/max and average
// registers, occupancy and the result register.
// ----------------------------------------------------------------------------
module fcr_datapath #(
  parameter int unsigned SLOTS    = 32,
  parameter int unsigned ITEM_IDS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fcr_pkg::ID_W-1:0]   item_id_i,
  input  fcr_pkg::cmd_t              cmd_i,
  output fcr_pkg::sts_t              sts_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [fcr_pkg::ID_W-1:0]   result_id_o,
  output logic [fcr_pkg::KIND_W-1:0] result_kind_o,
  output logic [fcr_pkg::CNT_W-1:0]  use_count_o,
  output logic                       last_o
);

  localparam int unsigned IW      = fcr_pkg::ID_W;
  localparam int unsigned CW      = fcr_pkg::CNT_W;
  localparam int unsigned ID_SPAN = 1 << IW;
  localparam int unsigned IDW     = $clog2(ITEM_IDS);
  localparam int unsigned SW      = $clog2(SLOTS);
  localparam int unsigned OCCW    = $clog2(SLOTS + 1);

  // id reduction table, worked out at elaboration
  logic [IW-1:0] id_tbl [ID_SPAN];
  for (genvar g = 0; g < ID_SPAN; g++) begin : g_id_tbl
    assign id_tbl[g] = IW'(g % ITEM_IDS);
  end

  logic [CW-1:0]   cnt_mem [ITEM_IDS];
  logic [IW-1:0]   slot_mem [SLOTS];

  logic [IW-1:0]   id_q;
  logic [CW-1:0]   cnt_q;
  logic            new_q;
  logic [CW-1:0]   cnt_rd_q;
  logic [IW-1:0]   slot_rd_q;
  logic [IW-1:0]   p2_id_q;
  logic [IDW-1:0]  clr_q;
  logic [OCCW-1:0] issue_q;
  logic [OCCW-1:0] w_q;
  logic [OCCW-1:0] occ_q;
  logic            p1_v_q;
  logic            p2_v_q;
  logic [CW-1:0]   mn_q;
  logic [CW-1:0]   mx_q;
  logic [CW-1:0]   avg_q;
  logic [CW-1:0]   cut_q;
  logic            out_v_q;
  logic [IW-1:0]   out_id_q;
  fcr_pkg::kind_e  out_kind_q;
  logic [CW-1:0]   out_cnt_q;
  logic            out_last_q;

  logic            run;
  logic            evict;
  logic            hold;
  logic            adv;
  logic            issue_more;
  logic            mm_act;
  logic            ev_act;
  logic            out_free;
  logic            scan_done;
  logic [CW-1:0]   cnt_inc;
  logic [CW:0]     span;
  logic [CW-1:0]   avg_d;
  logic [CW:0]     avg_p1;
  logic            cnt_we;
  logic [IDW-1:0]  cnt_waddr;
  logic [CW-1:0]   cnt_wdata;
  logic            cnt_re;
  logic [IDW-1:0]  cnt_raddr;
  logic            slot_we;
  logic [SW-1:0]   slot_waddr;
  logic [IW-1:0]   slot_wdata;
  logic            slot_re;

  assign run        = cmd_i.scan_mm | cmd_i.scan_ev;
  assign evict      = (cnt_rd_q <= avg_q);
  // hold the pipeline while an eviction waits for the result register
  assign hold       = cmd_i.scan_ev & p2_v_q & evict & out_v_q & out_stall_i;
  assign adv        = run & ~hold;
  assign issue_more = (issue_q != OCCW'(SLOTS));
  assign mm_act     = cmd_i.scan_mm & adv & p2_v_q;
  assign ev_act     = cmd_i.scan_ev & adv & p2_v_q;
  assign out_free   = ~out_v_q | ~out_stall_i;
  assign scan_done  = ~issue_more & ~p1_v_q & ~p2_v_q;

  assign cnt_inc = (cnt_rd_q == fcr_pkg::COUNT_MAX) ? cnt_rd_q : cnt_rd_q + CW'(1);

  assign span   = {1'b0, mx_q} - {1'b0, mn_q} + (CW + 1)'(1);
  assign avg_d  = mn_q + CW'(span >> 1);
  assign avg_p1 = {1'b0, avg_d} + (CW + 1)'(1);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = clr_q;
    cnt_wdata = '0;
    if (cmd_i.clr_step) begin
      cnt_we = 1'b1;
    end else if (cmd_i.update) begin
      cnt_we    = 1'b1;
      cnt_waddr = IDW'(id_q);
      cnt_wdata = cnt_inc;
    end else if (ev_act) begin
      cnt_we    = 1'b1;
      cnt_waddr = IDW'(p2_id_q);
      cnt_wdata = evict ? '0 : cnt_rd_q - cut_q;
    end
  end

  assign cnt_re    = cmd_i.lookup | adv;
  assign cnt_raddr = cmd_i.lookup ? IDW'(id_q) : IDW'(slot_rd_q);

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = w_q[SW-1:0];
    slot_wdata = p2_id_q;
    if (ev_act && !evict) begin
      slot_we = 1'b1;
    end else if (cmd_i.final_load && new_q) begin
      slot_we    = 1'b1;
      slot_waddr = occ_q[SW-1:0];
      slot_wdata = id_q;
    end
  end

  assign slot_re = adv & issue_more;

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[issue_q[SW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      issue_q <= '0;
      w_q     <= '0;
      occ_q   <= '0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + IDW'(1);
      end
      if (cmd_i.scan_start) begin
        issue_q <= '0;
        w_q     <= '0;
        p1_v_q  <= 1'b0;
        p2_v_q  <= 1'b0;
      end else if (adv) begin
        if (issue_more) begin
          issue_q <= issue_q + OCCW'(1);
        end
        p1_v_q <= issue_more;
        p2_v_q <= p1_v_q;
        if (ev_act && !evict) begin
          w_q <= w_q + OCCW'(1);
        end
      end
      if (cmd_i.scan_ev && scan_done) begin
        occ_q <= w_q;
      end else if (cmd_i.final_load && new_q) begin
        occ_q <= occ_q + OCCW'(1);
      end
      if (cmd_i.final_load || (ev_act && evict)) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      id_q <= id_tbl[item_id_i];
    end
    if (cmd_i.update) begin
      cnt_q <= cnt_inc;
      new_q <= (cnt_rd_q == '0);
    end
    if (adv) begin
      p2_id_q <= slot_rd_q;
    end
    if (cmd_i.scan_start) begin
      mn_q <= fcr_pkg::COUNT_MAX;
      mx_q <= '0;
    end else if (mm_act) begin
      if (cnt_rd_q < mn_q) begin
        mn_q <= cnt_rd_q;
      end
      if (cnt_rd_q > mx_q) begin
        mx_q <= cnt_rd_q;
      end
    end
    if (cmd_i.calc) begin
      avg_q <= avg_d;
      cut_q <= CW'(avg_p1 >> 1);
    end
    if (cmd_i.final_load) begin
      out_id_q   <= id_q;
      out_kind_q <= new_q ? fcr_pkg::KIND_NEW : fcr_pkg::KIND_CACHED;
      out_cnt_q  <= new_q ? CW'(1) : cnt_q;
      out_last_q <= 1'b1;
    end else if (ev_act && evict) begin
      out_id_q   <= p2_id_q;
      out_kind_q <= fcr_pkg::KIND_EVICT;
      out_cnt_q  <= '0;
      out_last_q <= 1'b0;
    end
  end

  assign sts_o.clr_last  = (clr_q == IDW'(ITEM_IDS - 1));
  assign sts_o.is_new    = (cnt_rd_q == '0);
  assign sts_o.full      = (occ_q == OCCW'(SLOTS));
  assign sts_o.scan_done = scan_done;
  assign sts_o.out_free  = out_free;

  assign out_valid_o   = out_v_q;
  assign result_id_o   = out_id_q;
  assign result_kind_o = out_kind_q;
  assign use_count_o   = out_cnt_q;
  assign last_o        = out_last_q;

endmodule
